[src/masked_interrupt_queue_assert.svh]
// Assertion macros for the masked interrupt queue checker.
// No dependencies; included by the checker file only.
`ifndef MASKED_INTERRUPT_QUEUE_ASSERT_SVH
`define MASKED_INTERRUPT_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define MIQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define MIQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/miq_pkg.sv]
// Package for the masked interrupt queue: sizes, codes and payload types.
// No dependencies; used by the top level and the checker.
`default_nettype none

package miq_pkg;

    // Queue and type sizing
    localparam int QUEUE_DEPTH = 16;
    localparam int TYPE_COUNT  = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int LVL_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int CNT_W       = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = TYPE_COUNT;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GLOBAL_ENABLE = 1'd0,
        CFG_TYPE_MASK     = 1'd1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_RECEIVE = 2'd0,
        OP_PROCESS = 2'd1,
        OP_SEND    = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_DISABLED  = 3'd1,
        ST_MASKED    = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_DELIVERED = 3'd5
    } t_status;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_EXEC = 1'b1
    } t_fsm;

    // One queued entry
    typedef struct packed {
        logic [3:0]  irq_type;
        logic [2:0]  irq_source;
        logic [31:0] irq_data;
    } t_entry;

    // Request payload
    typedef struct packed {
        t_op         operation;
        logic [3:0]  irq_type;
        logic [2:0]  irq_source;
        logic [31:0] irq_data;
    } t_req;

    // Result payload
    typedef struct packed {
        t_status          status;
        logic [3:0]       out_type;
        logic [2:0]       out_source;
        logic [31:0]      out_data;
        logic [LVL_W-1:0] queue_level;
        logic [CNT_W-1:0] sent_total;
        logic [CNT_W-1:0] received_total;
        logic [CNT_W-1:0] dropped_total;
        logic [CNT_W-1:0] masked_total;
    } t_res;

endpackage

`default_nettype wire

[src/masked_interrupt_queue.sv]
// Masked interrupt queue: one request per command, one result strobe per request.
// Depends on miq_pkg. Entry storage is a synchronous memory inside this module.
//
// A request is taken at a rising edge with start high and busy low; busy then
// stays high for the execute cycle, and the edge that ends it puts the result
// on o_res with o_strobe high for exactly one cycle.
// The receiver cannot stall, so the result must be captured in that cycle.
// A new request may be issued in the strobe cycle; none is taken while the
// previous one is executing. This is set by the entry memory: its read data is
// registered at the edge that takes the request and is used in the execute
// cycle, which also writes the memory and moves the pointers. Configuration
// writes take effect at once and should only be made while the block is idle.
`default_nettype none

module masked_interrupt_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  miq_pkg::t_req                 i_req,
    input  logic                          i_cfg_we,
    input  logic [miq_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [miq_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                          o_strobe,
    output miq_pkg::t_res                 o_res
);
    import miq_pkg::*;

    // Control state
    t_fsm                  r_state, n_state;
    logic                  w_accept;

    // Configuration registers
    logic                  r_global_en;
    logic [TYPE_COUNT-1:0] r_type_mask;

    // Queue state
    t_entry                r_mem [QUEUE_DEPTH];
    t_entry                r_rd_data;
    logic [PTR_W-1:0]      r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0]      r_wr_ptr, n_wr_ptr;
    logic [LVL_W-1:0]      r_level, n_level;

    // Counters
    logic [CNT_W-1:0]      r_sent, n_sent;
    logic [CNT_W-1:0]      r_recv, n_recv;
    logic [CNT_W-1:0]      r_drop, n_drop;
    logic [CNT_W-1:0]      r_mask, n_mask;

    // Captured request and result
    t_req                  r_req;
    t_res                  r_res, n_res;
    logic                  r_strobe;
    logic                  w_push;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            FSM_IDLE: begin
                if (start) n_state = FSM_EXEC;
            end
            FSM_EXEC: n_state = FSM_IDLE;
            default:  n_state = FSM_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        busy     = (r_state == FSM_EXEC);
        w_accept = start && (r_state == FSM_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FSM_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes; the index is fully decoded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_global_en <= 1'b1;
            r_type_mask <= '1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_GLOBAL_ENABLE: r_global_en <= i_cfg_data[0];
                CFG_TYPE_MASK:     r_type_mask <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (w_accept) r_req <= i_req;
    end

    // Execute: all decisions made in the cycle after the request is taken
    always_comb begin
        logic             type_blocked;
        logic [PTR_W-1:0] rd_adv;
        logic [PTR_W-1:0] wr_adv;

        type_blocked = ({{(32-4){1'b0}}, r_req.irq_type} < TYPE_COUNT)
                       && !r_type_mask[r_req.irq_type];
        rd_adv = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        wr_adv = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;

        n_rd_ptr   = r_rd_ptr;
        n_wr_ptr   = r_wr_ptr;
        n_level    = r_level;
        n_sent     = r_sent;
        n_recv     = r_recv;
        n_drop     = r_drop;
        n_mask     = r_mask;
        w_push     = 1'b0;
        n_res      = '0;
        n_res.status = ST_DONE;

        case (r_req.operation)
            OP_RECEIVE: begin
                if (!r_global_en) begin
                    n_mask       = r_mask + 1'b1;
                    n_res.status = ST_DISABLED;
                end else if (type_blocked) begin
                    n_mask       = r_mask + 1'b1;
                    n_res.status = ST_MASKED;
                end else if (r_level == LVL_W'(QUEUE_DEPTH)) begin
                    n_drop       = r_drop + 1'b1;
                    n_res.status = ST_FULL;
                end else begin
                    w_push   = 1'b1;
                    n_wr_ptr = wr_adv;
                    n_level  = r_level + 1'b1;
                    n_recv   = r_recv + 1'b1;
                end
            end
            OP_PROCESS: begin
                if (r_level == '0) begin
                    n_res.status = ST_EMPTY;
                end else begin
                    n_res.out_type   = r_rd_data.irq_type;
                    n_res.out_source = r_rd_data.irq_source;
                    n_res.out_data   = r_rd_data.irq_data;
                    n_rd_ptr         = rd_adv;
                    n_level          = r_level - 1'b1;
                    n_res.status     = ST_DELIVERED;
                end
            end
            OP_SEND: begin
                if (!r_global_en) begin
                    n_res.status = ST_DISABLED;
                end else begin
                    n_sent = r_sent + 1'b1;
                end
            end
            OP_CLEAR: begin
                n_sent = '0;
                n_recv = '0;
                n_drop = '0;
                n_mask = '0;
            end
            default: ;
        endcase

        n_res.queue_level    = n_level;
        n_res.sent_total     = n_sent;
        n_res.received_total = n_recv;
        n_res.dropped_total  = n_drop;
        n_res.masked_total   = n_mask;
    end

    // Pointers, level and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_level  <= '0;
            r_sent   <= '0;
            r_recv   <= '0;
            r_drop   <= '0;
            r_mask   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= busy;
            if (busy) begin
                r_rd_ptr <= n_rd_ptr;
                r_wr_ptr <= n_wr_ptr;
                r_level  <= n_level;
                r_sent   <= n_sent;
                r_recv   <= n_recv;
                r_drop   <= n_drop;
                r_mask   <= n_mask;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (busy) r_res <= n_res;
    end

    // Entry memory: write port
    always_ff @(posedge i_clk) begin
        if (busy && w_push) begin
            r_mem[r_wr_ptr] <= '{irq_type:   r_req.irq_type,
                                 irq_source: r_req.irq_source,
                                 irq_data:   r_req.irq_data};
        end
    end

    // Entry memory: read port, always at the head; pointer is settled before the
    // edge that takes any request, so no forwarding is needed
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_rd_ptr];
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

`default_nettype wire

[src/miq_checker.sv]
// Port-level checker for the masked interrupt queue, bound to the top level.
// Depends on miq_pkg and masked_interrupt_queue_assert.svh.
`default_nettype none

`include "masked_interrupt_queue_assert.svh"

module miq_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_strobe,
    input miq_pkg::t_res o_res
);
    import miq_pkg::*;

    // A taken request holds the block for its execute cycle
    `MIQ_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, start && !busy, busy, "busy missing after request")

    // Every taken request is followed by its result strobe
    `MIQ_ASSERT_NOW(a_result_latency, i_clk, i_rst_n, start && !busy, ##2 o_strobe, "result strobe missing")

    // A strobe only follows an execute cycle
    `MIQ_ASSERT_NOW(a_strobe_after_busy, i_clk, i_rst_n, o_strobe, $past(busy) && !busy, "stray result strobe")

    // The queue never reports more entries than it holds
    `MIQ_ASSERT_NOW(a_level_bound, i_clk, i_rst_n, o_strobe, o_res.queue_level <= (LVL_W)'(QUEUE_DEPTH), "queue level overrun")

    // Entry fields are zero unless an entry is delivered
    `MIQ_ASSERT_NOW(a_idle_fields_zero, i_clk, i_rst_n, o_strobe && (o_res.status != ST_DELIVERED), (o_res.out_type == '0) && (o_res.out_source == '0) && (o_res.out_data == '0), "entry fields not cleared")

endmodule

bind masked_interrupt_queue miq_checker u_miq_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_res    (o_res)
);

`default_nettype wire
